// ===== rtl/pola_pkg.sv =====
// Shared types and constants for the page ownership list allocator.
// Holds the operation codes, controller states and the command/status structs.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
`default_nettype none

package pola_pkg;

    // Default sizes of the link table and of the space tables.
    localparam int DEF_NUM_PAGES  = 1024;
    localparam int DEF_NUM_SPACES = 16;

    // Fixed widths of the word fields.
    localparam int FUNC_W  = 2;
    localparam int PAGE_W  = 10;
    localparam int SPACE_W = 4;
    localparam int COUNT_W = 11;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_ALLOC  = 2'd2
    } func_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_ALLOC_CHK,
        ST_ADD_RD,
        ST_ADD_CHK,
        ST_RM_START,
        ST_RM_HEAD,
        ST_WALK,
        ST_RM_LINK,
        ST_RM_CLR,
        ST_REPORT,
        ST_FINISH
    } state_t;

    // Source of the link table read address.
    typedef enum logic [1:0] {
        RD_TGT,
        RD_HEAD,
        RD_LINK
    } rd_src_t;

    // Source of the current space index.
    typedef enum logic {
        SP_IN,
        SP_FREE
    } sp_src_t;

    typedef struct packed {
        logic    capture;
        logic    clr_step;
        logic    sp_load;
        sp_src_t sp_src;
        logic    tgt_load;
        logic    tgt_from_head;
        logic    mem_re;
        rd_src_t rd_src;
        logic    push_write;
        logic    head_unlink;
        logic    walk_init;
        logic    walk_adv;
        logic    link_bypass;
        logic    tgt_clear;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic              clr_last;
        logic              sp_valid;
        logic              pg_valid;
        logic              fl_valid;
        logic [FUNC_W-1:0] func;
        logic              head_none;
        logic              head_is_tgt;
        logic              count_zero;
        logic              rd_none;
        logic              rd_is_tgt;
        logic              steps_last;
        logic              out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/pola_datapath.sv =====
// Datapath of the page ownership list allocator: link table memory, list heads,
// page counts, working registers and the result word register.
// Depends on pola_pkg; driven by pola_ctrl through pola_pkg::cmd_t.
`default_nettype none

module pola_datapath #(
    parameter int NUM_PAGES  = pola_pkg::DEF_NUM_PAGES,
    parameter int NUM_SPACES = pola_pkg::DEF_NUM_SPACES
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_write_en,
    input  wire  [pola_pkg::SPACE_W-1:0]     cfg_write_data,
    input  wire  [pola_pkg::FUNC_W-1:0]      func,
    input  wire  [pola_pkg::PAGE_W-1:0]      page_number,
    input  wire  [pola_pkg::SPACE_W-1:0]     space_index,
    input  wire pola_pkg::cmd_t              cmd,
    output pola_pkg::status_t                status,
    output logic                             ok,
    output logic [pola_pkg::PAGE_W-1:0]      granted_page,
    output logic [pola_pkg::COUNT_W-1:0]     space_pages,
    output logic                             out_valid,
    input  wire                              out_stall
);

    localparam int PW = $clog2(NUM_PAGES);
    localparam int LW = PW + 1;
    localparam int SW = $clog2(NUM_SPACES);
    localparam logic [LW-1:0] LINK_NONE = '1;

    logic [pola_pkg::SPACE_W-1:0] fl_reg;
    logic [pola_pkg::FUNC_W-1:0]  func_reg;
    logic [pola_pkg::PAGE_W-1:0]  pg_reg;
    logic [pola_pkg::SPACE_W-1:0] sp_reg;
    logic [SW-1:0]                cur_sp_reg;
    logic [PW-1:0]                tgt_reg;
    logic [PW-1:0]                pos_reg;
    logic [PW-1:0]                steps_reg;
    logic [PW-1:0]                clr_addr_reg;
    logic                         ok_reg;
    logic [LW-1:0]                rd_data_reg;

    logic [LW-1:0]                link_mem [NUM_PAGES];
    logic [LW-1:0]                head_reg [NUM_SPACES];
    logic [pola_pkg::COUNT_W-1:0] count_reg [NUM_SPACES];

    logic                         out_valid_reg;
    logic                         out_ok_reg;
    logic [pola_pkg::PAGE_W-1:0]  out_page_reg;
    logic [pola_pkg::COUNT_W-1:0] out_count_reg;

    logic [LW-1:0]                head_cur;
    logic [pola_pkg::COUNT_W-1:0] count_cur;
    logic                         sp_valid;
    logic                         mem_we;
    logic [PW-1:0]                mem_waddr;
    logic [LW-1:0]                mem_wdata;
    logic [PW-1:0]                mem_raddr;

    assign head_cur  = head_reg[cur_sp_reg];
    assign count_cur = count_reg[cur_sp_reg];
    assign sp_valid  = 32'(sp_reg) < NUM_SPACES;

    always_comb
    begin
        status.clr_last    = clr_addr_reg == PW'(NUM_PAGES - 1);
        status.sp_valid    = sp_valid;
        status.pg_valid    = 32'(pg_reg) < NUM_PAGES;
        status.fl_valid    = 32'(fl_reg) < NUM_SPACES;
        status.func        = func_reg;
        status.head_none   = head_cur == LINK_NONE;
        status.head_is_tgt = head_cur == {1'b0, tgt_reg};
        status.count_zero  = count_cur == '0;
        status.rd_none     = rd_data_reg == LINK_NONE;
        status.rd_is_tgt   = rd_data_reg == {1'b0, tgt_reg};
        status.steps_last  = steps_reg == PW'(NUM_PAGES - 1);
        status.out_free    = !out_valid_reg || !out_stall;
    end

    // Free pool register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fl_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            fl_reg <= cfg_write_data;
        end
    end

    // Clearing sweep address.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Working registers for the word in progress.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            pg_reg   <= page_number;
            sp_reg   <= space_index;
        end
        if (cmd.sp_load)
        begin
            cur_sp_reg <= (cmd.sp_src == pola_pkg::SP_FREE) ? SW'(fl_reg) : SW'(sp_reg);
        end
        if (cmd.tgt_load)
        begin
            tgt_reg <= cmd.tgt_from_head ? head_cur[PW-1:0] : PW'(pg_reg);
        end
        if (cmd.walk_init)
        begin
            pos_reg   <= head_cur[PW-1:0];
            steps_reg <= '0;
        end
        else if (cmd.walk_adv)
        begin
            pos_reg   <= rd_data_reg[PW-1:0];
            steps_reg <= steps_reg + 1'b1;
        end
        if (cmd.capture)
        begin
            ok_reg <= 1'b0;
        end
        else if (cmd.push_write || cmd.head_unlink || cmd.tgt_clear)
        begin
            ok_reg <= 1'b1;
        end
    end

    // Link table write and read port selection.
    always_comb
    begin
        mem_we    = 1'b1;
        mem_waddr = tgt_reg;
        mem_wdata = LINK_NONE;
        if (cmd.clr_step)
        begin
            mem_waddr = clr_addr_reg;
        end
        else if (cmd.push_write)
        begin
            mem_wdata = head_cur;
        end
        else if (cmd.link_bypass)
        begin
            mem_waddr = pos_reg;
            mem_wdata = rd_data_reg;
        end
        else if (!(cmd.head_unlink || cmd.tgt_clear))
        begin
            mem_we = 1'b0;
        end
    end

    always_comb
    begin
        case (cmd.rd_src)
            pola_pkg::RD_TGT:  mem_raddr = tgt_reg;
            pola_pkg::RD_HEAD: mem_raddr = head_cur[PW-1:0];
            pola_pkg::RD_LINK: mem_raddr = rd_data_reg[PW-1:0];
            default:           mem_raddr = tgt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_re)
        begin
            rd_data_reg <= link_mem[mem_raddr];
        end
    end

    // List heads and page counts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SPACES; i++)
            begin
                head_reg[i]  <= LINK_NONE;
                count_reg[i] <= '0;
            end
        end
        else if (cmd.push_write)
        begin
            head_reg[cur_sp_reg]  <= {1'b0, tgt_reg};
            count_reg[cur_sp_reg] <= count_cur + 1'b1;
        end
        else if (cmd.head_unlink)
        begin
            head_reg[cur_sp_reg]  <= rd_data_reg;
            count_reg[cur_sp_reg] <= count_cur - 1'b1;
        end
        else if (cmd.tgt_clear)
        begin
            count_reg[cur_sp_reg] <= count_cur - 1'b1;
        end
    end

    // Result word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_ok_reg    <= ok_reg;
            out_page_reg  <= (ok_reg && func_reg == pola_pkg::FUNC_ALLOC) ?
                             pola_pkg::PAGE_W'(tgt_reg) : '0;
            out_count_reg <= sp_valid ? count_cur : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign ok           = out_ok_reg;
    assign granted_page = out_page_reg;
    assign space_pages  = out_count_reg;

endmodule

`default_nettype wire

// ===== rtl/pola_ctrl.sv =====
// Controller of the page ownership list allocator: one state machine that
// sequences the clearing sweep, add, remove (list walk) and allocate.
// Depends on pola_pkg; drives pola_datapath through pola_pkg::cmd_t.
`default_nettype none

module pola_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  wire pola_pkg::status_t status,
    output pola_pkg::cmd_t       cmd
);

    pola_pkg::state_t state_reg;
    pola_pkg::state_t state_next;
    logic             is_alloc;

    assign is_alloc = status.func == pola_pkg::FUNC_ALLOC;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pola_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pola_pkg::ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = pola_pkg::ST_IDLE;
                end
            end
            pola_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = pola_pkg::ST_DECODE;
                end
            end
            pola_pkg::ST_DECODE:
            begin
                state_next = pola_pkg::ST_REPORT;
                if (status.sp_valid)
                begin
                    case (status.func)
                        pola_pkg::FUNC_ADD:
                        begin
                            if (status.pg_valid)
                            begin
                                state_next = pola_pkg::ST_ADD_RD;
                            end
                        end
                        pola_pkg::FUNC_REMOVE:
                        begin
                            if (status.pg_valid)
                            begin
                                state_next = pola_pkg::ST_RM_START;
                            end
                        end
                        pola_pkg::FUNC_ALLOC:
                        begin
                            state_next = pola_pkg::ST_ALLOC_CHK;
                        end
                        default:
                        begin
                            state_next = pola_pkg::ST_REPORT;
                        end
                    endcase
                end
            end
            pola_pkg::ST_ALLOC_CHK:
            begin
                if (status.fl_valid && !status.count_zero && !status.head_none)
                begin
                    state_next = pola_pkg::ST_RM_START;
                end
                else
                begin
                    state_next = pola_pkg::ST_REPORT;
                end
            end
            pola_pkg::ST_ADD_RD:
            begin
                state_next = pola_pkg::ST_ADD_CHK;
            end
            pola_pkg::ST_ADD_CHK:
            begin
                state_next = pola_pkg::ST_REPORT;
            end
            pola_pkg::ST_RM_START:
            begin
                if (status.head_none)
                begin
                    state_next = pola_pkg::ST_REPORT;
                end
                else if (status.head_is_tgt)
                begin
                    state_next = pola_pkg::ST_RM_HEAD;
                end
                else
                begin
                    state_next = pola_pkg::ST_WALK;
                end
            end
            pola_pkg::ST_RM_HEAD:
            begin
                state_next = is_alloc ? pola_pkg::ST_ADD_RD : pola_pkg::ST_REPORT;
            end
            pola_pkg::ST_WALK:
            begin
                if (status.rd_none)
                begin
                    state_next = pola_pkg::ST_REPORT;
                end
                else if (status.rd_is_tgt)
                begin
                    state_next = pola_pkg::ST_RM_LINK;
                end
                else if (status.steps_last)
                begin
                    state_next = pola_pkg::ST_REPORT;
                end
            end
            pola_pkg::ST_RM_LINK:
            begin
                state_next = pola_pkg::ST_RM_CLR;
            end
            pola_pkg::ST_RM_CLR:
            begin
                state_next = pola_pkg::ST_REPORT;
            end
            pola_pkg::ST_REPORT:
            begin
                state_next = pola_pkg::ST_FINISH;
            end
            pola_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = pola_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pola_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            pola_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            pola_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            pola_pkg::ST_DECODE:
            begin
                cmd.sp_load  = 1'b1;
                cmd.sp_src   = is_alloc ? pola_pkg::SP_FREE : pola_pkg::SP_IN;
                cmd.tgt_load = !is_alloc;
            end
            pola_pkg::ST_ALLOC_CHK:
            begin
                cmd.tgt_load      = 1'b1;
                cmd.tgt_from_head = 1'b1;
            end
            pola_pkg::ST_ADD_RD:
            begin
                cmd.mem_re = 1'b1;
                cmd.rd_src = pola_pkg::RD_TGT;
            end
            pola_pkg::ST_ADD_CHK:
            begin
                cmd.push_write = status.rd_none;
            end
            pola_pkg::ST_RM_START:
            begin
                cmd.mem_re    = 1'b1;
                cmd.rd_src    = status.head_is_tgt ? pola_pkg::RD_TGT : pola_pkg::RD_HEAD;
                cmd.walk_init = 1'b1;
            end
            pola_pkg::ST_RM_HEAD:
            begin
                cmd.head_unlink = 1'b1;
                cmd.sp_load     = is_alloc;
                cmd.sp_src      = pola_pkg::SP_IN;
            end
            pola_pkg::ST_WALK:
            begin
                if (!status.rd_none)
                begin
                    if (status.rd_is_tgt)
                    begin
                        cmd.mem_re = 1'b1;
                        cmd.rd_src = pola_pkg::RD_TGT;
                    end
                    else if (!status.steps_last)
                    begin
                        cmd.mem_re   = 1'b1;
                        cmd.rd_src   = pola_pkg::RD_LINK;
                        cmd.walk_adv = 1'b1;
                    end
                end
            end
            pola_pkg::ST_RM_LINK:
            begin
                cmd.link_bypass = 1'b1;
            end
            pola_pkg::ST_RM_CLR:
            begin
                cmd.tgt_clear = 1'b1;
            end
            pola_pkg::ST_REPORT:
            begin
                cmd.sp_load = 1'b1;
                cmd.sp_src  = pola_pkg::SP_IN;
            end
            pola_pkg::ST_FINISH:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/page_ownership_list_allocator.sv =====
// Page ownership list allocator: the top level.
// Instantiates pola_ctrl (sequencer) and pola_datapath (tables and registers).
// Depends on pola_pkg.
//
// Usage. An input word (func, page_number, space_index) is taken when in_valid
// is high and in_stall is low; each input word gives exactly one result word
// (ok, granted_page, space_pages), offered with out_valid and held while
// out_stall is high. Operation add pushes a page onto a space's list, remove
// unlinks it by walking the list from its head, allocate pops the head of the
// free pool space (set through cfg_write_en/cfg_write_data) onto the space.
// The block works on one word at a time. A remove of the page at the head
// of the list needs no walk; otherwise the walk follows one link per cycle
// through the single read port of the link table. After reset the block
// sweeps the link table to "none", one entry a cycle, with in_stall high;
// configuration writes are still taken then. A result waiting under
// out_stall does not stop the next word from being accepted; only its
// completion waits for the slot.
`default_nettype none

module page_ownership_list_allocator #(
    parameter int NUM_PAGES  = pola_pkg::DEF_NUM_PAGES,
    parameter int NUM_SPACES = pola_pkg::DEF_NUM_SPACES
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_write_en,
    input  wire  [pola_pkg::SPACE_W-1:0]     cfg_write_data,
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire  [pola_pkg::FUNC_W-1:0]      func,
    input  wire  [pola_pkg::PAGE_W-1:0]      page_number,
    input  wire  [pola_pkg::SPACE_W-1:0]     space_index,
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic                             ok,
    output logic [pola_pkg::PAGE_W-1:0]      granted_page,
    output logic [pola_pkg::COUNT_W-1:0]     space_pages
);

    // Commands flow from the sequencer to the datapath; status flows back.
    pola_pkg::cmd_t    cmd;
    pola_pkg::status_t status;

    pola_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    pola_datapath #(
        .NUM_PAGES  (NUM_PAGES),
        .NUM_SPACES (NUM_SPACES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .func           (func),
        .page_number    (page_number),
        .space_index    (space_index),
        .cmd            (cmd),
        .status         (status),
        .ok             (ok),
        .granted_page   (granted_page),
        .space_pages    (space_pages),
        .out_valid      (out_valid),
        .out_stall      (out_stall)
    );

endmodule

`default_nettype wire

// ===== tb/tb_page_ownership_list_allocator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the page ownership list allocator.
// Depends on pola_pkg and page_ownership_list_allocator from rtl/; needs nothing else.

module tb_page_ownership_list_allocator;

    import pola_pkg::*;

    localparam int NUM_PAGES  = DEF_NUM_PAGES;
    localparam int NUM_SPACES = DEF_NUM_SPACES;

    // Links are one bit wider than a page number, so that "none" (all ones)
    // can never be mistaken for a real page.
    localparam int LINK_W = PAGE_W + 1;
    localparam logic [LINK_W-1:0] LINK_NONE = '1;

    // The one operation code that the package leaves without a name.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // Cycles with no word taken on either side before the run is abandoned.
    // The slowest legal gap is the sweep after reset or a full remove walk,
    // stretched by stalls on the result side.
    localparam int WATCHDOG_LIMIT = 8 * NUM_PAGES;

    typedef struct packed {
        logic               ok;
        logic [PAGE_W-1:0]  granted_page;
        logic [COUNT_W-1:0] space_pages;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               cfg_write_en = 1'b0;
    logic [SPACE_W-1:0] cfg_write_data = '0;

    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [FUNC_W-1:0]  func = '0;
    logic [PAGE_W-1:0]  page_number = '0;
    logic [SPACE_W-1:0] space_index = '0;

    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               ok;
    logic [PAGE_W-1:0]  granted_page;
    logic [COUNT_W-1:0] space_pages;

    // Percentages that the current phase applies to the two sides.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    int mismatch_count = 0;

    // Expected result words, oldest first, one per accepted input word.
    outcome_t pending_outcomes[$];

    // Shadow copy of the ownership lists and of the pool register.
    logic [LINK_W-1:0]  link_tbl  [NUM_PAGES];
    logic [LINK_W-1:0]  head_tbl  [NUM_SPACES];
    logic [COUNT_W-1:0] count_tbl [NUM_SPACES];
    logic [SPACE_W-1:0] pool_space;

    page_ownership_list_allocator #(
        .NUM_PAGES  (NUM_PAGES),
        .NUM_SPACES (NUM_SPACES)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .page_number    (page_number),
        .space_index    (space_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ok             (ok),
        .granted_page   (granted_page),
        .space_pages    (space_pages)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow list operations
    // ------------------------------------------------------------------

    // Pushes a page onto the front of a space's list. A page whose link is
    // not "none" is refused; a list tail reads "none" and so gets through.
    function automatic bit push_page_onto(input logic [PAGE_W-1:0] pg,
                                          input logic [SPACE_W-1:0] sp);
        if (link_tbl[pg] != LINK_NONE)
            return 1'b0;
        link_tbl[pg]  = head_tbl[sp];
        head_tbl[sp]  = {1'b0, pg};
        count_tbl[sp] = count_tbl[sp] + 1'b1;
        return 1'b1;
    endfunction

    // Unlinks a page from a space's list, walking from the head. The walk
    // gives up after NUM_PAGES links, since a re-added tail can close a loop.
    function automatic bit unlink_page_from(input logic [PAGE_W-1:0] pg,
                                            input logic [SPACE_W-1:0] sp);
        logic [LINK_W-1:0] pos;
        logic [LINK_W-1:0] nxt;
        bit found;
        pos = head_tbl[sp];
        found = 1'b0;
        if (pos == LINK_NONE)
            return 1'b0;
        if (pos == {1'b0, pg})
        begin
            head_tbl[sp] = link_tbl[pos[PAGE_W-1:0]];
            link_tbl[pos[PAGE_W-1:0]] = LINK_NONE;
        end
        else
        begin
            for (int steps = 0; steps < NUM_PAGES; steps++)
            begin
                nxt = link_tbl[pos[PAGE_W-1:0]];
                if (nxt == LINK_NONE)
                    return 1'b0;
                if (nxt == {1'b0, pg})
                begin
                    found = 1'b1;
                    break;
                end
                pos = nxt;
            end
            if (!found)
                return 1'b0;
            link_tbl[pos[PAGE_W-1:0]] = link_tbl[pg];
            link_tbl[pg] = LINK_NONE;
        end
        // The count wraps at 2048 in both directions.
        count_tbl[sp] = count_tbl[sp] - 1'b1;
        return 1'b1;
    endfunction

    // Applies one input word to the shadow lists and returns the result
    // word that the block ought to give for it.
    function automatic outcome_t predict_outcome(input logic [FUNC_W-1:0]  f,
                                                 input logic [PAGE_W-1:0]  pg,
                                                 input logic [SPACE_W-1:0] sp);
        outcome_t res;
        logic [LINK_W-1:0] top;
        res = '0;
        case (f)
            FUNC_ADD:    res.ok = push_page_onto(pg, sp);
            FUNC_REMOVE: res.ok = unlink_page_from(pg, sp);
            FUNC_ALLOC:
            begin
                // The pool must have both a non-zero count and a head.
                if (count_tbl[pool_space] != '0 && head_tbl[pool_space] != LINK_NONE)
                begin
                    top = head_tbl[pool_space];
                    void'(unlink_page_from(top[PAGE_W-1:0], pool_space));
                    void'(push_page_onto(top[PAGE_W-1:0], sp));
                    res.granted_page = top[PAGE_W-1:0];
                    res.ok = 1'b1;
                end
            end
            default: res.ok = 1'b0;
        endcase
        res.space_pages = count_tbl[sp];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // A page that the block will accept for an add, if one turns up quickly.
    function automatic logic [PAGE_W-1:0] pick_unlinked_page();
        logic [PAGE_W-1:0] cand;
        cand = PAGE_W'($urandom);
        for (int tries = 0; tries < 16; tries++)
        begin
            if (link_tbl[cand] == LINK_NONE)
                return cand;
            cand = PAGE_W'($urandom);
        end
        return cand;
    endfunction

    // A page a few links down a space's list, so that removes mostly hit.
    function automatic logic [PAGE_W-1:0] pick_listed_page(input logic [SPACE_W-1:0] sp);
        logic [LINK_W-1:0] pos;
        logic [PAGE_W-1:0] any_page;
        int hops;
        pos = head_tbl[sp];
        any_page = PAGE_W'($urandom);
        if (pos == LINK_NONE)
            return any_page;
        hops = $urandom_range(48);
        for (int i = 0; i < hops; i++)
        begin
            if (link_tbl[pos[PAGE_W-1:0]] == LINK_NONE)
                break;
            pos = link_tbl[pos[PAGE_W-1:0]];
        end
        return pos[PAGE_W-1:0];
    endfunction

    // Offers one input word and waits until the block takes it. It is
    // entered just after a rising edge and returns just after the edge of
    // acceptance with in_valid still high, so that a following word can
    // go straight out without valid dropping in between.
    task automatic send_word(input logic [FUNC_W-1:0]  f,
                             input logic [PAGE_W-1:0]  pg,
                             input logic [SPACE_W-1:0] sp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= f;
        page_number <= pg;
        space_index <= sp;
        do
            @(posedge clk);
        while (in_stall);
        pending_outcomes.push_back(predict_outcome(f, pg, sp));
    endtask

    // Stops sending and waits until every outstanding result word is in.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // Writes the pool register. Only called while the block is idle.
    task automatic write_pool_space(input logic [SPACE_W-1:0] v);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        pool_space = v;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Relies on the pool register's reset value of space 0. Covers the
    // empty pool, the unused operation code, the field extremes, an
    // allocate into the pool's own space and removes that hit and that miss.
    task automatic test_reset_state();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_word(FUNC_ALLOC,  10'h2AA, 4'd5);
        send_word(FUNC_UNUSED, 10'h3FF, 4'd15);
        send_word(FUNC_ADD,    10'h000, 4'd0);
        send_word(FUNC_ADD,    10'h3FF, 4'd0);
        send_word(FUNC_ALLOC,  10'h155, 4'd15);
        send_word(FUNC_ALLOC,  10'h3FF, 4'd0);
        send_word(FUNC_REMOVE, 10'h3FF, 4'd15);
        send_word(FUNC_REMOVE, 10'h3FF, 4'd15);
        send_word(FUNC_REMOVE, 10'h005, 4'd0);
        wait_for_results();
    endtask

    // Drives one space's count below zero and back over the top. Page 341
    // sits on space 1 and is then pushed onto space 2 ahead of page 682,
    // so unlinking it from space 1 leaves space 1 headed by 682 with a
    // count of zero. The next remove wraps the count to 2047 and an add
    // wraps it back to zero, leaving a pool with a head but no count.
    task automatic test_count_wrap();
        write_pool_space(4'd1);
        send_word(FUNC_ADD,    10'd682, 4'd2);
        send_word(FUNC_ADD,    10'd341, 4'd1);
        send_word(FUNC_ADD,    10'd341, 4'd2);
        send_word(FUNC_REMOVE, 10'd341, 4'd1);
        send_word(FUNC_REMOVE, 10'd682, 4'd1);
        send_word(FUNC_ADD,    10'd512, 4'd1);
        send_word(FUNC_ALLOC,  10'd0,   4'd3);
        wait_for_results();
    endtask

    // Adding a lone page twice links it to itself; a remove of any other
    // page then walks the loop until the bound stops it. Ends with an
    // allocate from the top pool space into that same space.
    task automatic test_bounded_walk();
        write_pool_space(4'd15);
        send_word(FUNC_ADD,    10'd7, 4'd3);
        send_word(FUNC_ADD,    10'd7, 4'd3);
        send_word(FUNC_REMOVE, 10'd8, 4'd3);
        send_word(FUNC_REMOVE, 10'd7, 4'd3);
        send_word(FUNC_REMOVE, 10'd7, 4'd3);
        send_word(FUNC_ADD,    10'd7, 4'd15);
        send_word(FUNC_ALLOC,  10'd0, 4'd15);
        wait_for_results();
    endtask

    // Mostly well-formed traffic: adds of unlinked pages, half of them into
    // the pool, removes of pages that are on the list, and allocates, with
    // some blind words and the unused code mixed in. With pause_midway the
    // sender holds off halfway until the block has answered everything.
    task automatic test_random_traffic(input int n_words,
                                       input logic [SPACE_W-1:0] pool,
                                       input int idle_pct,
                                       input int stall_pct,
                                       input bit pause_midway);
        logic [FUNC_W-1:0]  f;
        logic [PAGE_W-1:0]  pg;
        logic [SPACE_W-1:0] sp;
        int sel;
        write_pool_space(pool);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n_words; i++)
        begin
            if (pause_midway && i == n_words / 2)
                wait_for_results();
            sel = $urandom_range(99);
            pg  = PAGE_W'($urandom);
            sp  = SPACE_W'($urandom_range(NUM_SPACES - 1));
            if (sel < 38)
            begin
                f = FUNC_ADD;
                if ($urandom_range(99) < 50)
                    sp = pool_space;
                if ($urandom_range(99) < 70)
                    pg = pick_unlinked_page();
            end
            else if (sel < 70)
            begin
                f = FUNC_REMOVE;
                if ($urandom_range(99) < 50)
                    sp = pool_space;
                if ($urandom_range(99) < 75)
                    pg = pick_listed_page(sp);
            end
            else if (sel < 95)
            begin
                f = FUNC_ALLOC;
            end
            else
            begin
                f = FUNC_UNUSED;
            end
            send_word(f, pg, sp);
        end
        wait_for_results();
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Every accepted result word is matched against the oldest expectation.
    always @(posedge clk)
    begin : check_results
        outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_outcomes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: stray result word: ok=%0b granted=%0d pages=%0d",
                             $realtime, ok, granted_page, space_pages);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (ok !== want.ok || granted_page !== want.granted_page ||
                    space_pages !== want.space_pages)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $write("%0t: mismatch: expected ok=%0b granted=%0d pages=%0d,",
                               $realtime, want.ok, want.granted_page, want.space_pages);
                        $display(" got ok=%0b granted=%0d pages=%0d",
                                 ok, granted_page, space_pages);
                    end
                end
            end
        end
    end

    // Abandons the run if neither side moves a word for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("[page_ownership_list_allocator] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------

    initial
    begin
        for (int i = 0; i < NUM_PAGES; i++)
            link_tbl[i] = LINK_NONE;
        for (int i = 0; i < NUM_SPACES; i++)
        begin
            head_tbl[i]  = LINK_NONE;
            count_tbl[i] = '0;
        end
        pool_space = '0;

        // The block sweeps its link table after reset with in_stall high,
        // which send_word simply waits out.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_count_wrap();
        test_bounded_walk();
        test_random_traffic(140, 4'd0,  0,  0,  1'b0);
        test_random_traffic(140, 4'd15, 45, 0,  1'b1);
        test_random_traffic(140, 4'($urandom_range(NUM_SPACES - 1)), 0, 45, 1'b0);
        test_random_traffic(140, 4'd6,  14, 14, 1'b0);

        // Leave room for a stray result word after the last expected one.
        repeat (NUM_PAGES + 16) @(posedge clk);
        if (mismatch_count == 0)
            $display("[page_ownership_list_allocator] OK");
        else
            $display("[page_ownership_list_allocator] ERROR");
        $finish;
    end

endmodule
